>>> hdl/urpf_pkg.sv
// urpf_pkg: constants, function codes and the controller/datapath command
// type for the packet framer. No dependencies.

package urpf_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int RING_DEPTH   = 8;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int RING_W = $clog2(RING_DEPTH);

    // field widths fixed by the interface
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int RADDR_W  = 10;
    localparam int OFF_W    = 10;
    localparam int LEN_W    = 11;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(512);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_IDLE    = 2'd1,
        FUNC_DEQUEUE = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef struct packed {
        logic capture;   // latch accepted item
        logic exec;      // carry out the item's work
        logic load_out;  // move result into output register
    } urpf_cmd_t;

endpackage

>>> hdl/urpf_ctrl.sv
// urpf_ctrl: handshake controller for the packet framer.
// Depends on urpf_pkg; drives urpf_dp through urpf_cmd_t.

module urpf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output urpf_pkg::urpf_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/urpf_dp.sv
// urpf_dp: datapath of the packet framer - byte buffer, pointers,
// descriptor ring and output register. Depends on urpf_pkg.

module urpf_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  urpf_pkg::urpf_cmd_t             cmd,
    input  logic                            cfg_we,
    input  logic [urpf_pkg::LEN_W-1:0]      cfg_wdata,
    input  logic [urpf_pkg::FUNC_W-1:0]     func,
    input  logic [urpf_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [urpf_pkg::RADDR_W-1:0]    read_addr,
    output logic                            packet_closed,
    output logic                            desc_valid,
    output logic [urpf_pkg::OFF_W-1:0]      desc_offset,
    output logic [urpf_pkg::LEN_W-1:0]      desc_len,
    output logic [urpf_pkg::BYTE_W-1:0]     read_data
);

    localparam int PTR_W  = urpf_pkg::PTR_W;
    localparam int ADDR_W = urpf_pkg::ADDR_W;
    localparam int RING_W = urpf_pkg::RING_W;
    localparam logic [PTR_W:0] BUF_SIZE = (PTR_W+1)'(urpf_pkg::BUFFER_BYTES);

    // captured item
    urpf_pkg::func_t                  func_reg;
    logic [urpf_pkg::BYTE_W-1:0]      rx_byte_reg;
    logic [urpf_pkg::RADDR_W-1:0]     read_addr_reg;

    // framing state
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  ps_reg, ps_next;
    logic [RING_W-1:0] head_reg, head_next;
    logic [RING_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0]  max_len_reg, max_len_next;

    logic [urpf_pkg::BYTE_W-1:0] mem [urpf_pkg::BUFFER_BYTES];
    logic [PTR_W-1:0]            ring_off_reg [urpf_pkg::RING_DEPTH];
    logic [PTR_W-1:0]            ring_len_reg [urpf_pkg::RING_DEPTH];

    // result held between exec and load
    logic                        closed_reg, closed_next;
    logic                        valid_reg, valid_next;
    logic [PTR_W-1:0]            off_reg, off_next;
    logic [PTR_W-1:0]            len_reg, len_next;
    logic                        rd_ok_reg;
    logic [urpf_pkg::BYTE_W-1:0] rd_data_reg;

    // output register
    logic                        closed_out_reg;
    logic                        valid_out_reg;
    logic [urpf_pkg::OFF_W-1:0]  off_out_reg;
    logic [urpf_pkg::LEN_W-1:0]  len_out_reg;
    logic [urpf_pkg::BYTE_W-1:0] data_out_reg;

    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  count;
    logic [PTR_W:0]    wrap_sum;
    logic [RING_W-1:0] tail_inc;
    logic [RING_W-1:0] head_inc;
    logic              do_close;
    logic              wr_en;
    logic              rd_ok;
    logic [PTR_W-1:0]  rd_ext;
    logic [ADDR_W-1:0] rd_idx;
    logic [PTR_W:0]    cfg_ext;

    // clamp length register to 1..BUFFER_BYTES on write
    always_comb
    begin
        cfg_ext = (PTR_W+1)'(cfg_wdata);
        if (cfg_ext == '0)
        begin
            max_len_next = PTR_W'(1);
        end
        else if (cfg_ext > BUF_SIZE)
        begin
            max_len_next = BUF_SIZE[PTR_W-1:0];
        end
        else
        begin
            max_len_next = cfg_ext[PTR_W-1:0];
        end
    end

    assign rd_ext = PTR_W'(read_addr_reg);
    assign rd_idx = rd_ext[ADDR_W-1:0];
    assign rd_ok  = ((PTR_W+1)'(read_addr_reg) < BUF_SIZE);
    assign wr_en  = cmd.exec && (func_reg == urpf_pkg::FUNC_RX_BYTE)
                    && ({1'b0, wp_reg} < BUF_SIZE);

    assign tail_inc = tail_reg + RING_W'(1);
    assign head_inc = head_reg + RING_W'(1);

    always_comb
    begin
        wp_next     = wp_reg;
        ps_next     = ps_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        closed_next = 1'b0;
        valid_next  = 1'b0;
        off_next    = '0;
        len_next    = '0;
        do_close    = 1'b0;
        wp_inc      = wp_reg;
        count       = wp_reg - ps_reg;

        case (func_reg)
            urpf_pkg::FUNC_RX_BYTE:
            begin
                wp_inc   = wp_reg + PTR_W'(1);
                count    = wp_inc - ps_reg;
                wp_next  = wp_inc;
                do_close = (count >= max_len_reg) || ({1'b0, wp_inc} >= BUF_SIZE);
            end
            urpf_pkg::FUNC_IDLE:
            begin
                do_close = (count != '0);
            end
            urpf_pkg::FUNC_DEQUEUE:
            begin
                if (head_reg != tail_reg)
                begin
                    head_next  = head_inc;
                    valid_next = 1'b1;
                    off_next   = ring_off_reg[head_inc];
                    len_next   = ring_len_reg[head_inc];
                end
            end
            default:
            begin
            end
        endcase

        wrap_sum = {1'b0, wp_inc} + {1'b0, max_len_reg};
        if (do_close)
        begin
            closed_next = 1'b1;
            tail_next   = tail_inc;
            ps_next     = wp_inc;
            if (wrap_sum > BUF_SIZE)
            begin
                ps_next = '0;
                wp_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            ps_reg      <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            max_len_reg <= PTR_W'(urpf_pkg::MAX_LEN_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= max_len_next;
            end
            if (cmd.exec)
            begin
                wp_reg   <= wp_next;
                ps_reg   <= ps_next;
                head_reg <= head_next;
                tail_reg <= tail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= urpf_pkg::func_t'(func);
            rx_byte_reg   <= rx_byte;
            read_addr_reg <= read_addr;
        end
        if (wr_en)
        begin
            mem[wp_reg[ADDR_W-1:0]] <= rx_byte_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_idx];
            rd_ok_reg   <= rd_ok && (func_reg == urpf_pkg::FUNC_READ);
            closed_reg  <= closed_next;
            valid_reg   <= valid_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            if (do_close)
            begin
                ring_off_reg[tail_inc] <= ps_reg;
                ring_len_reg[tail_inc] <= count;
            end
        end
        if (cmd.load_out)
        begin
            closed_out_reg <= closed_reg;
            valid_out_reg  <= valid_reg;
            off_out_reg    <= urpf_pkg::OFF_W'(off_reg);
            len_out_reg    <= urpf_pkg::LEN_W'(len_reg);
            data_out_reg   <= rd_ok_reg ? rd_data_reg : '0;
        end
    end

    assign packet_closed = closed_out_reg;
    assign desc_valid    = valid_out_reg;
    assign desc_offset   = off_out_reg;
    assign desc_len      = len_out_reg;
    assign read_data     = data_out_reg;

endmodule

>>> hdl/uart_rx_packet_framer.sv
// uart_rx_packet_framer: top level, joins urpf_ctrl and urpf_dp.
// Depends on urpf_pkg, urpf_ctrl, urpf_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | func, rx_byte, read_addr
//   out      | out_valid/ out_ready | packet_closed, desc_valid, desc_offset,
//            |                      | desc_len, read_data
//   cfg      | cfg_we (no wait)     | cfg_wdata (max_packet_len)
//
// An item is accepted, executed (buffer port, pointer and ring update),
// then loaded into the output register. The next item is accepted while
// a result waits in the output register; a stalled output holds the
// controller in its final state. Reset clears pointers, ring indices and
// the length register (512); buffer and ring contents are not cleared.

module uart_rx_packet_framer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [urpf_pkg::LEN_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [urpf_pkg::FUNC_W-1:0]     func,
    input  logic [urpf_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [urpf_pkg::RADDR_W-1:0]    read_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            packet_closed,
    output logic                            desc_valid,
    output logic [urpf_pkg::OFF_W-1:0]      desc_offset,
    output logic [urpf_pkg::LEN_W-1:0]      desc_len,
    output logic [urpf_pkg::BYTE_W-1:0]     read_data
);

    urpf_pkg::urpf_cmd_t cmd;

    urpf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    urpf_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .rx_byte       (rx_byte),
        .read_addr     (read_addr),
        .packet_closed (packet_closed),
        .desc_valid    (desc_valid),
        .desc_offset   (desc_offset),
        .desc_len      (desc_len),
        .read_data     (read_data)
    );

endmodule

>>> tb/uart_rx_packet_framer_tb.sv
// uart_rx_packet_framer_tb: self-checking testbench for the packet framer.
// Holds a scoreboard class with its own framer model. Plain tasks drive the
// handshakes. Depends on urpf_pkg and uart_rx_packet_framer.
`timescale 1ns / 100ps

module uart_rx_packet_framer_tb;

    import urpf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              closed;
        logic              dvalid;
        logic [OFF_W-1:0]  doff;
        logic [LEN_W-1:0]  dlen;
        logic [BYTE_W-1:0] rdata;
    } framer_result_t;

    class framer_scoreboard;
        logic [BYTE_W-1:0] rx_store [BUFFER_BYTES];
        bit                stored [BUFFER_BYTES];
        int unsigned       stored_addrs [$];
        int unsigned       wr_ptr;
        int unsigned       pkt_start;
        logic [RING_W-1:0] head;
        logic [RING_W-1:0] tail;
        logic [OFF_W-1:0]  ring_off [RING_DEPTH];
        logic [LEN_W-1:0]  ring_len [RING_DEPTH];
        logic [LEN_W-1:0]  max_len;
        framer_result_t    expected_q [$];
        int                errors;
        bit                last_closed;

        function new();
            wr_ptr      = 0;
            pkt_start   = 0;
            head        = '0;
            tail        = '0;
            max_len     = MAX_LEN_RESET;
            errors      = 0;
            last_closed = 1'b0;
        endfunction

        function void set_max_len(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int unsigned effective_max();
            if (max_len == 0)
                return 1;
            if (max_len > BUFFER_BYTES)
                return BUFFER_BYTES;
            return max_len;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [RADDR_W-1:0] pick_addr();
            return RADDR_W'(stored_addrs[$urandom_range(stored_addrs.size() - 1)]);
        endfunction

        function void queue_packet(int unsigned count);
            tail           = tail + 1'b1;
            ring_off[tail] = OFF_W'(pkt_start);
            ring_len[tail] = LEN_W'(count);
            pkt_start      = wr_ptr;
            if (pkt_start + effective_max() > BUFFER_BYTES)
            begin
                pkt_start = 0;
                wr_ptr    = 0;
            end
        endfunction

        function void note_item(func_t f, logic [BYTE_W-1:0] b, logic [RADDR_W-1:0] a);
            framer_result_t r;
            int unsigned    count;
            r = '0;
            case (f)
                FUNC_RX_BYTE:
                begin
                    rx_store[wr_ptr] = b;
                    if (!stored[wr_ptr])
                    begin
                        stored[wr_ptr] = 1'b1;
                        stored_addrs.push_back(wr_ptr);
                    end
                    wr_ptr++;
                    count = wr_ptr - pkt_start;
                    if (count >= effective_max() || wr_ptr >= BUFFER_BYTES)
                    begin
                        queue_packet(count);
                        r.closed = 1'b1;
                    end
                end
                FUNC_IDLE:
                begin
                    count = wr_ptr - pkt_start;
                    if (count != 0)
                    begin
                        queue_packet(count);
                        r.closed = 1'b1;
                    end
                end
                FUNC_DEQUEUE:
                begin
                    if (head != tail)
                    begin
                        head     = head + 1'b1;
                        r.dvalid = 1'b1;
                        r.doff   = ring_off[head];
                        r.dlen   = ring_len[head];
                    end
                end
                default:
                    r.rdata = rx_store[a];
            endcase
            last_closed = r.closed;
            expected_q.push_back(r);
        endfunction

        function void check_result(framer_result_t got);
            framer_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.closed !== want.closed || got.dvalid !== want.dvalid ||
                got.doff !== want.doff || got.dlen !== want.dlen ||
                got.rdata !== want.rdata)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch (exp/act) closed %0d/%0d valid %0d/%0d ",
                              "offset %0d/%0d len %0d/%0d data %02h/%02h"}, $realtime,
                             want.closed, got.closed, want.dvalid, got.dvalid,
                             want.doff, got.doff, want.dlen, got.dlen,
                             want.rdata, got.rdata);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LEN_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [BYTE_W-1:0]   rx_byte;
    logic [RADDR_W-1:0]  read_addr;
    logic                out_valid;
    logic                out_ready;
    logic                packet_closed;
    logic                desc_valid;
    logic [OFF_W-1:0]    desc_offset;
    logic [LEN_W-1:0]    desc_len;
    logic [BYTE_W-1:0]   read_data;

    framer_scoreboard    sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic                hold_rx;
    bit                  pressure_go;

    uart_rx_packet_framer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .rx_byte       (rx_byte),
        .read_addr     (read_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_closed (packet_closed),
        .desc_valid    (desc_valid),
        .desc_offset   (desc_offset),
        .desc_len      (desc_len),
        .read_data     (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        hold_rx = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
        out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result('{closed: packet_closed, dvalid: desc_valid,
                              doff: desc_offset, dlen: desc_len, rdata: read_data});
    end

    task automatic send_item(input func_t f, input logic [BYTE_W-1:0] b,
                             input logic [RADDR_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        rx_byte   <= b;
        read_addr <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(f, b, a);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(FUNC_RX_BYTE, b, RADDR_W'($urandom));
    endtask

    task automatic send_any_op();
        func_t f;
        f = func_t'($urandom_range(3));
        send_item(f, BYTE_W'($urandom),
                  (f == FUNC_READ) ? sb.pick_addr() : RADDR_W'($urandom));
    endtask

    // register writes only with nothing in flight
    task automatic set_max_len(input logic [LEN_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_max_len(v);
    endtask

    // packets of random bytes closed by idle, with reads, dequeues and noise
    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        int lim;
        int i;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_any_op();
                sent++;
            end
            else
            begin
                lim = sb.effective_max();
                len = $urandom_range(1, (lim > 22) ? 24 : lim + 2);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(11) == 0)
                    begin
                        send_any_op();
                        sent++;
                    end
                    send_byte(BYTE_W'($urandom));
                    sent++;
                end
                if ($urandom_range(4) != 0)
                begin
                    send_item(FUNC_IDLE, BYTE_W'($urandom), RADDR_W'($urandom));
                    sent++;
                end
                repeat ($urandom_range(0, 3))
                begin
                    send_any_op();
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        func        = FUNC_RX_BYTE;
        rx_byte     = '0;
        read_addr   = '0;
        out_ready   = 1'b0;
        pressure_go = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 85;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_item(FUNC_IDLE, 8'h00, 10'h000);       // idle, nothing open
        send_item(FUNC_DEQUEUE, 8'h00, 10'h000);    // empty ring
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_item(FUNC_IDLE, 8'h00, 10'h000);
        send_item(FUNC_DEQUEUE, 8'h00, 10'h000);
        send_item(FUNC_READ, 8'h00, 10'h000);
        send_item(FUNC_READ, 8'h00, 10'h002);
        set_max_len(LEN_W'(0));                     // behaves as one
        send_byte(8'hA5);
        send_byte(8'h3C);
        send_item(FUNC_DEQUEUE, 8'h00, 10'h000);
        send_item(FUNC_DEQUEUE, 8'h00, 10'h000);
        set_max_len(LEN_W'(8));
        repeat (5) send_byte(BYTE_W'($urandom));
        set_max_len(LEN_W'(2));                     // lowered mid-packet
        send_byte(BYTE_W'($urandom));
        set_max_len(LEN_W'(1));
        repeat (7) send_byte(BYTE_W'($urandom));   // tail catches head
        send_item(FUNC_DEQUEUE, 8'h00, 10'h000);

        set_max_len(LEN_W'(3));
        random_traffic(110);

        send_idle_pct = 85;
        recv_idle_pct = 26;
        set_max_len(LEN_W'(16));
        random_traffic(110);
        set_max_len(LEN_W'($urandom_range(1, 64)));
        random_traffic(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // open a fresh packet away from offset 0, then run with the largest length
        set_max_len(LEN_W'(40));
        do
            send_byte(BYTE_W'($urandom));
        while (!sb.last_closed);
        set_max_len(LEN_W'(2047));                  // behaves as the buffer size
        random_traffic(60);

        set_max_len(LEN_W'(5));
        pressure_go = 1'b1;
        random_traffic(60);
        set_max_len(LEN_W'($urandom_range(0, 2047)));
        random_traffic(80);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
